// ----- rtl/core/rbyuv_pkg.sv -----
// rbyuv_pkg: shared types and coefficients for the 2x2 rgb block to yuv 4:2:0 converter
// used by rbyuv_pixel, rbyuv_chroma and rgb_block_to_yuv420; no dependencies

package rbyuv_pkg;

   // coefficients, bt.601-style integer weights
   localparam logic [15:0] LUMA_R      = 16'd77;
   localparam logic [15:0] LUMA_G      = 16'd150;
   localparam logic [15:0] LUMA_B      = 16'd29;
   localparam logic [15:0] CHROMA_BIAS = 16'd32768;
   localparam logic [15:0] U_R         = 16'd43;
   localparam logic [15:0] U_G         = 16'd85;
   localparam logic [15:0] U_B         = 16'd128;
   localparam logic [15:0] V_R         = 16'd128;
   localparam logic [15:0] V_G         = 16'd107;
   localparam logic [15:0] V_B         = 16'd21;
   localparam int          CHROMA_SHIFT = 10;

   localparam int PIXELS     = 4;
   localparam int TERM_W     = 16;
   localparam int CSUM_W     = TERM_W + 2;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 48;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [7:0]        luma;
      logic [TERM_W-1:0] u_term;
      logic [TERM_W-1:0] v_term;
   } pix_term_type;

endpackage

// ----- rtl/core/rgb_block_to_yuv420.sv -----
// rgb_block_to_yuv420: top level, 2x2 bgr block to four luma bytes and shared u and v
// depends on rbyuv_pkg, rbyuv_pixel and rbyuv_chroma

// One request carries a 2x2 block of 8-bit pixels (blue, green, red each) and gives exactly
// one response: four luma bytes (77r+150g+29b)>>8 and one u and one v byte for the block,
// each the sum of four biased pixel terms shifted right by 10; no clamping is needed since
// every value lands in 0..255. The block takes one request per clock cycle while req_tready
// stays high. A taken request is held in the input register; once the result register is
// free, the conversion logic feeds it from there and rsp_tvalid rises. The input register
// still takes a new request while a finished response waits on rsp_tready as long as the
// input register itself is empty or moving on; with both registers full and rsp_tready
// low, req_tready drops. Reset clears only the two valid flags.

module rgb_block_to_yuv420 (
   input  logic                             clock,
   input  logic                             reset,
   // tl_blue, tl_green, tl_red, tr_blue, tr_green, tr_red,
   // bl_blue, bl_green, bl_red, br_blue, br_green, br_red (8 bits each, lowest first)
   input  logic [rbyuv_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // luma_tl, luma_tr, luma_bl, luma_br, chroma_u, chroma_v (8 bits each, lowest first)
   output logic [rbyuv_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);

   // input register
   logic                             s1_valid_ff, s1_valid_in;
   logic [rbyuv_pkg::REQ_DATA_W-1:0] s1_data_ff, s1_data_in;
   // result register
   logic                             s2_valid_ff, s2_valid_in;
   logic [rbyuv_pkg::RSP_DATA_W-1:0] s2_data_ff, s2_data_in;

   logic s2_ready;
   logic s1_ready;

   rbyuv_pkg::pixel_type    pix  [rbyuv_pkg::PIXELS];
   rbyuv_pkg::pix_term_type term [rbyuv_pkg::PIXELS];
   logic [7:0]              chroma_u;
   logic [7:0]              chroma_v;

   // result register frees when empty or being drained this cycle
   assign s2_ready   = !s2_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   // unpack pixels: each pixel is blue, green, red from the low byte up
   for (genvar k = 0; k < rbyuv_pkg::PIXELS; k++) begin : g_pix
      assign pix[k].blue  = s1_data_ff[24*k +: 8];
      assign pix[k].green = s1_data_ff[24*k + 8 +: 8];
      assign pix[k].red   = s1_data_ff[24*k + 16 +: 8];

      rbyuv_pixel u_pixel (
         .pix  (pix[k]),
         .term (term[k])
      );
   end

   rbyuv_chroma u_chroma (
      .term     (term),
      .chroma_u (chroma_u),
      .chroma_v (chroma_v)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (s1_ready) begin
         s1_valid_in = req_tvalid;
         s1_data_in  = req_tdata;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_data_in  = s2_data_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
         s2_data_in  = {chroma_v, chroma_u, term[3].luma, term[2].luma,
                        term[1].luma, term[0].luma};
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s2_data_ff <= s2_data_in;
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = s2_data_ff;

   // a stalled input register keeps its block
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("input register lost or changed a stalled block");

   // a block moving out of the input register always lands in the result register
   a_s1_to_s2: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_ready) |=> s2_valid_ff)
      else $error("block dropped between input and result register");

   // an accepted request always shows up in the input register
   a_req_to_s1: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (s1_valid_ff && s1_data_ff == $past(req_tdata)))
      else $error("accepted request not captured");

   // with both stages full and the output stalled, no request may be taken
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while pipeline is full");

endmodule

// ----- rtl/core/rbyuv_pixel.sv -----
// rbyuv_pixel: per-pixel luma and the pixel's u and v chroma terms
// depends on rbyuv_pkg

module rbyuv_pixel (
   input  rbyuv_pkg::pixel_type    pix,
   output rbyuv_pkg::pix_term_type term
);

   logic [15:0] luma_sum;
   logic [15:0] u_sub;
   logic [15:0] v_sub;

   assign luma_sum = 16'(pix.red)   * rbyuv_pkg::LUMA_R
                   + 16'(pix.green) * rbyuv_pkg::LUMA_G
                   + 16'(pix.blue)  * rbyuv_pkg::LUMA_B;

   // subtracted parts never exceed the bias, so the terms stay positive
   assign u_sub = 16'(pix.red) * rbyuv_pkg::U_R + 16'(pix.green) * rbyuv_pkg::U_G;
   assign v_sub = 16'(pix.green) * rbyuv_pkg::V_G + 16'(pix.blue) * rbyuv_pkg::V_B;

   assign term.luma   = luma_sum[15:8];
   assign term.u_term = rbyuv_pkg::CHROMA_BIAS + 16'(pix.blue) * rbyuv_pkg::U_B - u_sub;
   assign term.v_term = rbyuv_pkg::CHROMA_BIAS + 16'(pix.red) * rbyuv_pkg::V_R - v_sub;

endmodule

// ----- rtl/core/rbyuv_chroma.sv -----
// rbyuv_chroma: sums the four pixel chroma terms and scales to one u and one v byte
// depends on rbyuv_pkg

module rbyuv_chroma (
   input  rbyuv_pkg::pix_term_type term [rbyuv_pkg::PIXELS],
   output logic [7:0]               chroma_u,
   output logic [7:0]               chroma_v
);

   logic [rbyuv_pkg::CSUM_W-1:0] u_sum;
   logic [rbyuv_pkg::CSUM_W-1:0] v_sum;

   assign u_sum = rbyuv_pkg::CSUM_W'(term[0].u_term) + rbyuv_pkg::CSUM_W'(term[1].u_term)
                + rbyuv_pkg::CSUM_W'(term[2].u_term) + rbyuv_pkg::CSUM_W'(term[3].u_term);
   assign v_sum = rbyuv_pkg::CSUM_W'(term[0].v_term) + rbyuv_pkg::CSUM_W'(term[1].v_term)
                + rbyuv_pkg::CSUM_W'(term[2].v_term) + rbyuv_pkg::CSUM_W'(term[3].v_term);

   assign chroma_u = u_sum[rbyuv_pkg::CHROMA_SHIFT +: 8];
   assign chroma_v = v_sum[rbyuv_pkg::CHROMA_SHIFT +: 8];

endmodule

// ----- tb/rgb_block_to_yuv420_tb.sv -----
// rgb_block_to_yuv420_tb: self-checking bench for the 2x2 rgb block to yuv 4:2:0 converter
// predicts luma, u and v for every accepted request and checks each response in order
// depends on rbyuv_pkg and rgb_block_to_yuv420
`timescale 1ns / 1ps

module rgb_block_to_yuv420_tb;

   // conversion weights, kept apart from the package so a wrong package value shows up
   localparam int W_LUMA_R = 77;
   localparam int W_LUMA_G = 150;
   localparam int W_LUMA_B = 29;
   localparam int W_BIAS   = 32768;
   localparam int W_U_R    = 43;
   localparam int W_U_G    = 85;
   localparam int W_U_B    = 128;
   localparam int W_V_R    = 128;
   localparam int W_V_G    = 107;
   localparam int W_V_B    = 21;
   localparam int W_SHIFT  = 10;

   localparam int RESET_CYCLES  = 8;
   localparam int LONG_HOLD     = 150;   // receiver hold-off while the sender keeps pushing
   localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake before giving up
   localparam int TAIL_CYCLES   = 10;    // time for any stray response still in the registers to show up
   localparam int REPORT_LIMIT  = 10;

   // request layout, first field lowest: tl, tr, bl, br; each pixel blue, green, red
   typedef struct packed {
      rbyuv_pkg::pixel_type br;
      rbyuv_pkg::pixel_type bl;
      rbyuv_pkg::pixel_type tr;
      rbyuv_pkg::pixel_type tl;
   } rgb_block_type;

   // response layout, last field lowest
   typedef struct packed {
      logic [7:0] chroma_v;
      logic [7:0] chroma_u;
      logic [7:0] luma_br;
      logic [7:0] luma_bl;
      logic [7:0] luma_tr;
      logic [7:0] luma_tl;
   } yuv_block_type;

   logic                             clock;
   logic                             reset      = 1'b1;
   logic [rbyuv_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [rbyuv_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;

   yuv_block_type yuv_expected[$];
   int         fault_count   = 0;
   int         send_idle_pct = 0;   // chance per cycle that the sender holds back a request
   int         rsp_stall_pct = 0;   // chance per cycle that the receiver drops rsp_tready
   int         holds_asked   = 0;   // bumped by a test to ask the receiver for a long hold
   int         holds_served  = 0;
   int         hold_left     = 0;

   string field_names [6] = '{"luma_tl", "luma_tr", "luma_bl", "luma_br",
                              "chroma_u", "chroma_v"};

   rgb_block_to_yuv420 i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------------------

   // luma per pixel, u and v summed over the four biased pixel terms then scaled down
   function automatic yuv_block_type convert_block(input rgb_block_type blk);
      rbyuv_pkg::pixel_type px [4];
      logic [7:0]           luma [4];
      int                   r, g, b;
      int                   u_total, v_total;
      yuv_block_type        res;
      px[0]   = blk.tl;
      px[1]   = blk.tr;
      px[2]   = blk.bl;
      px[3]   = blk.br;
      u_total = 0;
      v_total = 0;
      for (int k = 0; k < 4; k++) begin
         r       = int'(px[k].red);
         g       = int'(px[k].green);
         b       = int'(px[k].blue);
         luma[k] = 8'((W_LUMA_R * r + W_LUMA_G * g + W_LUMA_B * b) >> 8);
         u_total += W_BIAS + W_U_B * b - W_U_R * r - W_U_G * g;
         v_total += W_BIAS + W_V_R * r - W_V_G * g - W_V_B * b;
      end
      res.luma_tl  = luma[0];
      res.luma_tr  = luma[1];
      res.luma_bl  = luma[2];
      res.luma_br  = luma[3];
      res.chroma_u = 8'(u_total >> W_SHIFT);
      res.chroma_v = 8'(v_total >> W_SHIFT);
      return res;
   endfunction

   // ---------------------------------------------------------------------------------------
   // scoreboard: push a prediction on every accepted request, check every accepted response
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin : scoreboard
      yuv_block_type got, want;
      if (!reset) begin
         // push first so a response in the same cycle as its request would still find its prediction
         if (req_tvalid && req_tready)
            yuv_expected.push_back(convert_block(rgb_block_type'(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            got = yuv_block_type'(rsp_tdata);
            if (yuv_expected.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("%0t: response %h with no request pending", $realtime, got);
            end else begin
               want = yuv_expected.pop_front();
               for (int k = 0; k < 6; k++) begin
                  if (got[8*k +: 8] !== want[8*k +: 8]) begin
                     fault_count++;
                     if (fault_count <= REPORT_LIMIT)
                        $display("%0t: %s expected %0d got %0d", $realtime, field_names[k],
                                 want[8*k +: 8], got[8*k +: 8]);
                  end
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // receiver: random stalls, plus a long hold-off when a test asks for one
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_tready   <= 1'b0;
         hold_left    <= LONG_HOLD - 1;
         holds_served <= holds_served + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // watchdog: ends the run when no request or response moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------

   function automatic rbyuv_pkg::pixel_type make_pixel(input logic [7:0] b, g, r);
      rbyuv_pkg::pixel_type px;
      px.blue  = b;
      px.green = g;
      px.red   = r;
      return px;
   endfunction

   function automatic rgb_block_type flat_block(input logic [7:0] b, g, r);
      rgb_block_type blk;
      blk.tl = make_pixel(b, g, r);
      blk.tr = blk.tl;
      blk.bl = blk.tl;
      blk.br = blk.tl;
      return blk;
   endfunction

   // bytes lean toward the rails so extreme chroma shows up often
   function automatic logic [7:0] random_byte();
      unique case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic rgb_block_type random_block();
      logic [rbyuv_pkg::REQ_DATA_W-1:0] raw;
      for (int k = 0; k < 12; k++)
         raw[8*k +: 8] = random_byte();
      return rgb_block_type'(raw);
   endfunction

   // offer one request, with random idle cycles first, and wait until it is taken
   task automatic send_request(input rgb_block_type blk);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom, $urandom};   // junk while not valid
         @(posedge clock);
      end
      req_tdata  <= blk;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // sender goes quiet until every predicted response has come back
   // it waits for a clock edge first so the last accepted request is surely on the queue
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (yuv_expected.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // flat colors at the rails and a few mixed blocks; yellow drives u and cyan drives v to
   // zero, blue drives u and red drives v to full scale, white gives full luma
   task automatic test_directed();
      rgb_block_type blk;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_request(flat_block(8'h00, 8'h00, 8'h00));
      send_request(flat_block(8'hFF, 8'hFF, 8'hFF));
      send_request(flat_block(8'h00, 8'h00, 8'hFF));   // red
      send_request(flat_block(8'h00, 8'hFF, 8'h00));   // green
      send_request(flat_block(8'hFF, 8'h00, 8'h00));   // blue
      send_request(flat_block(8'hFF, 8'hFF, 8'h00));   // cyan
      send_request(flat_block(8'h00, 8'hFF, 8'hFF));   // yellow
      send_request(flat_block(8'hFF, 8'h00, 8'hFF));   // magenta
      send_request(flat_block(8'hAA, 8'hAA, 8'hAA));
      send_request(flat_block(8'h55, 8'h55, 8'h55));
      send_request(flat_block(8'h80, 8'h7F, 8'h01));
      blk.tl = make_pixel(8'hFF, 8'hFF, 8'hFF);
      blk.tr = make_pixel(8'h00, 8'h00, 8'h00);
      blk.bl = make_pixel(8'h00, 8'h00, 8'hFF);
      blk.br = make_pixel(8'hFF, 8'h00, 8'h00);
      send_request(blk);
      blk.tl = make_pixel(8'h00, 8'hFF, 8'hFF);
      blk.tr = make_pixel(8'hFF, 8'hFF, 8'h00);
      blk.bl = make_pixel(8'h00, 8'hFF, 8'h00);
      blk.br = make_pixel(8'hFF, 8'h00, 8'hFF);
      send_request(blk);
      send_request(rgb_block_type'({12{8'h01}} << 4));
      wait_for_drain();
   endtask

   // random blocks under one idling pattern on each side
   task automatic test_random_stream(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_request(random_block());
      wait_for_drain();
   endtask

   // receiver holds off for a long stretch while the sender keeps offering requests,
   // so both registers fill and req_tready has to drop
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      holds_asked++;
      repeat (40) send_request(random_block());
      wait_for_drain();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_stream(100, 0, 0);
      test_random_stream(100, 88, 0);
      test_random_stream(100, 0, 88);
      test_random_stream(100, 26, 26);
      test_backpressure();

      // all requests answered; give the block a few cycles to show any stray response
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
